### design/frsm_pkg.sv
package frsm_pkg;

    // operation codes carried in the opcode field
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_PUSH    = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // orientation codes of the result word
    localparam logic [1:0] ORIENT_NONE    = 2'd0;
    localparam logic [1:0] ORIENT_ORIGIN  = 2'd1;
    localparam logic [1:0] ORIENT_ROTATED = 2'd2;

    // configuration register indexes
    localparam logic CFG_NATIVE_HEIGHT = 1'b0;
    localparam logic CFG_NATIVE_WIDTH  = 1'b1;

    localparam int DIM_W      = 13;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        logic latch_in;
        logic do_acquire;
        logic do_push;
        logic do_fail;
        logic scan_start;
        logic scan_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       none_filled;
        logic       scan_hit;
        logic       out_free;
    } sts_t;

endpackage

### design/frame_ring_slot_manager.sv
// channel   dir  fields (low bit up)                                  handshake
// s_        in   opcode[1:0] frame_height[14:2] frame_width[27:15]    s_tvalid/s_tready
// m_        out  slot_index[1:0] orientation[3:2] ok[4] count[7:5]    m_tvalid/m_tready
// cfg_      in   cfg_index 0 native_height, 1 native_width           cfg_valid/cfg_ready
//
// acquire, push, opcode three and a read of an empty ring go from accept through the
// execute and response states to the result; any other read also passes the scan state,
// stepping from the read pointer to the next filled slot; words are taken only in idle.
// aresetn is synchronous: slots empty, pointers, count, native sizes and output valid zero.
// a stalled result keeps the following word waiting in the response state;
// one finished result sits in the output register while the next word is being worked on.
module frame_ring_slot_manager #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // opcode, frame_height, frame_width, zero pad
    input  logic [frsm_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // slot_index, orientation, ok, filled_count
    output logic [frsm_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [frsm_pkg::DIM_W-1:0]          cfg_data
);

    frsm_pkg::cmd_t cmd;
    frsm_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    frsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    frsm_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### design/frsm_ctrl.sv
module frsm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  frsm_pkg::sts_t sts,
    output frsm_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESP;
                unique case (sts.opcode)
                    frsm_pkg::OP_ACQUIRE: cmd.do_acquire = 1'b1;
                    frsm_pkg::OP_PUSH:    cmd.do_push    = 1'b1;
                    frsm_pkg::OP_READ: begin
                        if (sts.none_filled) begin
                            cmd.do_fail = 1'b1;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default: cmd.do_fail = 1'b1;
                endcase
            end
            ST_SCAN: begin
                // a filled slot is always found since the count was non-zero
                cmd.scan_step = 1'b1;
                if (sts.scan_hit) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

### design/frsm_datapath.sv
module frsm_datapath #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [frsm_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_index,
    input  logic [frsm_pkg::DIM_W-1:0]          cfg_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [frsm_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  frsm_pkg::cmd_t                      cmd,
    output frsm_pkg::sts_t                      sts
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] n;
        n = (s == LAST_SLOT) ? '0 : s + 1'b1;
        return n;
    endfunction

    logic [1:0]                  op_reg;
    logic [frsm_pkg::DIM_W-1:0]  height_reg;
    logic [frsm_pkg::DIM_W-1:0]  width_reg;
    logic [frsm_pkg::DIM_W-1:0]  native_h_reg;
    logic [frsm_pkg::DIM_W-1:0]  native_w_reg;
    logic [SLOT_COUNT-1:0]       filled_reg;
    logic [SLOT_COUNT-1:0]       rot_reg;
    logic [IDX_W-1:0]            wr_ptr_reg;
    logic [IDX_W-1:0]            rd_ptr_reg;
    logic [IDX_W-1:0]            scan_ptr_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [IDX_W-1:0]            res_slot_reg;
    logic [1:0]                  res_orient_reg;
    logic                        res_ok_reg;
    logic                        out_valid_reg;
    logic [frsm_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic             size_match;
    logic             scan_hit;
    logic [IDX_W-1:0] acq_slot;

    assign size_match = (height_reg == native_h_reg) && (width_reg == native_w_reg);
    assign scan_hit   = filled_reg[scan_ptr_reg];
    // acquire steps past the slot the consumer holds
    assign acq_slot   = (wr_ptr_reg == rd_ptr_reg) ? next_slot(wr_ptr_reg) : wr_ptr_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            native_h_reg <= '0;
            native_w_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == frsm_pkg::CFG_NATIVE_HEIGHT) begin
                native_h_reg <= cfg_data;
            end else begin
                native_w_reg <= cfg_data;
            end
        end
    end

    // latched input word
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg     <= s_tdata[1:0];
            height_reg <= s_tdata[14:2];
            width_reg  <= s_tdata[27:15];
        end
    end

    // ring state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg   <= '0;
            rot_reg      <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            scan_ptr_reg <= '0;
            count_reg    <= '0;
        end else begin
            if (cmd.do_acquire) begin
                wr_ptr_reg <= acq_slot;
            end
            if (cmd.do_push) begin
                filled_reg[wr_ptr_reg] <= 1'b1;
                rot_reg[wr_ptr_reg]    <= !size_match;
                if (!filled_reg[wr_ptr_reg]) begin
                    count_reg <= count_reg + 1'b1;
                end
                wr_ptr_reg <= next_slot(wr_ptr_reg);
            end
            if (cmd.scan_start) begin
                scan_ptr_reg <= next_slot(rd_ptr_reg);
            end
            if (cmd.scan_step) begin
                if (scan_hit) begin
                    filled_reg[scan_ptr_reg] <= 1'b0;
                    rd_ptr_reg               <= scan_ptr_reg;
                    count_reg                <= count_reg - 1'b1;
                end else begin
                    scan_ptr_reg <= next_slot(scan_ptr_reg);
                end
            end
        end
    end

    // result fields of the current operation
    always_ff @(posedge aclk) begin
        if (cmd.do_acquire) begin
            res_slot_reg   <= acq_slot;
            res_orient_reg <= frsm_pkg::ORIENT_NONE;
            res_ok_reg     <= 1'b1;
        end else if (cmd.do_push) begin
            res_slot_reg   <= '0;
            res_orient_reg <= frsm_pkg::ORIENT_NONE;
            res_ok_reg     <= 1'b1;
        end else if (cmd.do_fail) begin
            res_slot_reg   <= '0;
            res_orient_reg <= frsm_pkg::ORIENT_NONE;
            res_ok_reg     <= 1'b0;
        end else if (cmd.scan_step && scan_hit) begin
            res_slot_reg   <= scan_ptr_reg;
            res_orient_reg <= rot_reg[scan_ptr_reg] ? frsm_pkg::ORIENT_ROTATED
                                                    : frsm_pkg::ORIENT_ORIGIN;
            res_ok_reg     <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {3'(count_reg), res_ok_reg, res_orient_reg, 2'(res_slot_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign sts.opcode      = op_reg;
    assign sts.none_filled = (count_reg == '0);
    assign sts.scan_hit    = scan_hit;
    assign sts.out_free    = !out_valid_reg || m_tready;

    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(filled_reg)))
        else $error("filled count out of step with slot flags");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |-> count_reg != '0)
        else $error("scan started on an empty ring");

    a_hit_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step && scan_hit |=> count_reg == $past(count_reg) - 1'b1)
        else $error("read hit did not drop the filled count");

    a_ptrs_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg <= LAST_SLOT) && (rd_ptr_reg <= LAST_SLOT) && (scan_ptr_reg <= LAST_SLOT))
        else $error("slot pointer beyond the ring");

endmodule

### tb/frame_ring_slot_manager_tb.sv
`timescale 1ns / 100ps

module frame_ring_slot_manager_tb;

    localparam int SLOTS = 4;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [frsm_pkg::DIM_W-1:0] DIM_MAX = '1;

    // same bit order as m_tdata: slot_index, orientation, ok, filled_count
    typedef struct packed {
        logic [2:0] count;
        logic       ok;
        logic [1:0] orient;
        logic [1:0] slot;
    } ring_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [frsm_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b1;
    logic [frsm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic                            cfg_index = frsm_pkg::CFG_NATIVE_HEIGHT;
    logic [frsm_pkg::DIM_W-1:0]      cfg_data  = '0;

    // shadow of the ring
    logic [1:0]                 slot_state [SLOTS];
    int                         wr_ptr = 0;
    int                         rd_ptr = 0;
    logic [frsm_pkg::DIM_W-1:0] nat_height = '0;
    logic [frsm_pkg::DIM_W-1:0] nat_width  = '0;

    ring_result_t pending_results [$];
    int           mismatch_count = 0;
    bit           steady_flow = 1'b0;
    int           stall_left = 0;

    frame_ring_slot_manager dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        foreach (slot_state[i]) slot_state[i] = frsm_pkg::ORIENT_NONE;
    end

    function automatic int filled_slots();
        int n;
        n = 0;
        foreach (slot_state[i]) if (slot_state[i] != frsm_pkg::ORIENT_NONE) n++;
        return n;
    endfunction

    function automatic logic [frsm_pkg::DIM_W-1:0] rand_dim();
        return frsm_pkg::DIM_W'($urandom_range(0, 2**frsm_pkg::DIM_W - 1));
    endfunction

    // advances the shadow ring by one operation and returns the word it should emit
    function automatic ring_result_t ring_outcome(logic [1:0] op,
                                                  logic [frsm_pkg::DIM_W-1:0] h,
                                                  logic [frsm_pkg::DIM_W-1:0] w);
        ring_result_t r;
        int p;
        bit found;
        r = '0;
        case (op)
            frsm_pkg::OP_ACQUIRE: begin
                // never hand out the slot the consumer is on
                if (wr_ptr == rd_ptr) wr_ptr = (wr_ptr + 1) % SLOTS;
                r.slot = wr_ptr[1:0];
                r.ok   = 1'b1;
            end
            frsm_pkg::OP_PUSH: begin
                slot_state[wr_ptr] = (h == nat_height && w == nat_width) ?
                                     frsm_pkg::ORIENT_ORIGIN : frsm_pkg::ORIENT_ROTATED;
                wr_ptr = (wr_ptr + 1) % SLOTS;
                r.ok   = 1'b1;
            end
            frsm_pkg::OP_READ: begin
                if (filled_slots() != 0) begin
                    p = rd_ptr;
                    found = 1'b0;
                    for (int k = 0; k < SLOTS && !found; k++) begin
                        p = (p + 1) % SLOTS;
                        found = (slot_state[p] != frsm_pkg::ORIENT_NONE);
                    end
                    rd_ptr = p;
                    r.slot   = p[1:0];
                    r.orient = slot_state[p];
                    slot_state[p] = frsm_pkg::ORIENT_NONE;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = 3'(filled_slots());
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // result side: random back-pressure (none in steady flow) and compare against the oldest expectation
    always @(posedge aclk) begin
        ring_result_t got;
        ring_result_t want;
        got = m_tdata;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("word with nothing pending", int'(got), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.slot !== want.slot)
                    flag_mismatch("slot_index", int'(got.slot), int'(want.slot));
                if (got.orient !== want.orient)
                    flag_mismatch("orientation", int'(got.orient), int'(want.orient));
                if (got.ok !== want.ok)
                    flag_mismatch("ok", int'(got.ok), int'(want.ok));
                if (got.count !== want.count)
                    flag_mismatch("filled_count", int'(got.count), int'(want.count));
            end
            stall_left = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall_left != 0) m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) m_tready <= 1'b1;
        end
    end

    // leaves s_tvalid high so back-to-back words need no second assignment
    task automatic send_word(logic [1:0] op, logic [frsm_pkg::DIM_W-1:0] h,
                             logic [frsm_pkg::DIM_W-1:0] w);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {4'b0, w, h, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(ring_outcome(op, h, w));
    endtask

    task automatic settle_ring();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_dims(logic [frsm_pkg::DIM_W-1:0] h, logic [frsm_pkg::DIM_W-1:0] w);
        settle_ring();
        cfg_valid <= 1'b1;
        cfg_index <= frsm_pkg::CFG_NATIVE_HEIGHT;
        cfg_data  <= h;
        do @(posedge aclk); while (!cfg_ready);
        nat_height = h;
        cfg_index <= frsm_pkg::CFG_NATIVE_WIDTH;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        nat_width = w;
        cfg_valid <= 1'b0;
    endtask

    // half the time the native size, else near misses, extremes and noise
    function automatic logic [frsm_pkg::DIM_W-1:0] pick_dim(logic [frsm_pkg::DIM_W-1:0] native);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return native;
            5:             return native ^ (13'd1 << $urandom_range(0, frsm_pkg::DIM_W - 1));
            6:             return '0;
            7:             return DIM_MAX;
            default:       return rand_dim();
        endcase
    endfunction

    task automatic test_empty_ring();
        send_word(frsm_pkg::OP_READ, '0, '0);
        send_word(OP_UNUSED, DIM_MAX, DIM_MAX);
        send_word(frsm_pkg::OP_ACQUIRE, '0, '0);
        send_word(frsm_pkg::OP_PUSH, '0, '0);
        send_word(frsm_pkg::OP_READ, '0, '0);
    endtask

    task automatic test_size_match();
        write_dims(DIM_MAX, 13'd4096);
        send_word(frsm_pkg::OP_PUSH, DIM_MAX, 13'd4096);
        send_word(frsm_pkg::OP_PUSH, DIM_MAX, 13'd4095);
        send_word(frsm_pkg::OP_PUSH, '0, 13'd4096);
        send_word(frsm_pkg::OP_PUSH, 13'd4096, DIM_MAX);
        repeat (4) send_word(frsm_pkg::OP_READ, '0, '0);
    endtask

    task automatic test_overwrite_and_skip();
        write_dims('0, '0);
        send_word(frsm_pkg::OP_PUSH, '0, '0);
        for (int i = 0; i < 4; i++) send_word(frsm_pkg::OP_PUSH, DIM_MAX, '0);
        send_word(frsm_pkg::OP_ACQUIRE, '0, '0);
        repeat (5) send_word(frsm_pkg::OP_READ, '0, '0);
        send_word(frsm_pkg::OP_ACQUIRE, '0, '0);
    endtask

    task automatic run_traffic(int n);
        int sent;
        int pick;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_word(frsm_pkg::OP_ACQUIRE, rand_dim(), rand_dim());
                send_word(frsm_pkg::OP_PUSH, pick_dim(nat_height), pick_dim(nat_width));
                sent += 2;
            end else begin
                if (pick < 75)
                    send_word(frsm_pkg::OP_READ, rand_dim(), rand_dim());
                else if (pick < 85)
                    send_word(frsm_pkg::OP_PUSH, pick_dim(nat_height), pick_dim(nat_width));
                else if (pick < 95)
                    send_word(frsm_pkg::OP_ACQUIRE, rand_dim(), rand_dim());
                else
                    send_word(OP_UNUSED, rand_dim(), rand_dim());
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        write_dims(rand_dim(), rand_dim());
        run_traffic(60);
        settle_ring();   // producer holds off until every pending result has been received
        run_traffic(40);
        write_dims(DIM_MAX, DIM_MAX);
        run_traffic(100);
        write_dims('0, '0);
        steady_flow = 1'b1;
        run_traffic(100);
        steady_flow = 1'b0;
        write_dims(13'd4096, frsm_pkg::DIM_W'($urandom_range(0, 4096)));
        run_traffic(100);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_ring();
        test_size_match();
        test_overwrite_and_skip();
        test_random_traffic();
        settle_ring();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
